@@ rtl/riscv_load_store_address_decoder_macros.svh @@
// assertion macros for the load/store address decoder
// each checker is sampled on clk and held off while rst_n is low
`ifndef RISCV_LOAD_STORE_ADDRESS_DECODER_MACROS_SVH
`define RISCV_LOAD_STORE_ADDRESS_DECODER_MACROS_SVH

`ifndef SYNTH

`define RLSAD_ASSERT(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("check failed");

`define RLSAD_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

`define RLSAD_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`else

`define RLSAD_ASSERT(label, expr)

`define RLSAD_IMPLIES(label, ante, cons)

`define RLSAD_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/rlsad_pkg.sv @@
package rlsad_pkg;

    localparam int XLEN     = 64;
    localparam int REG_BITS = 5;
    localparam int NUM_REGS = 31;

    // command codes
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_STORE = 2'd2;

    // major opcodes of the full-length encodings
    localparam logic [6:0] OPC_LOAD  = 7'b0000011;
    localparam logic [6:0] OPC_STORE = 7'b0100011;
    localparam logic [1:0] LEN_FULL  = 2'b11;

    // compressed quadrant zero and its funct3 codes
    localparam logic [1:0] C_QUAD0 = 2'b00;
    localparam logic [2:0] C_F3_LW = 3'b010;
    localparam logic [2:0] C_F3_LD = 3'b011;
    localparam logic [2:0] C_F3_SW = 3'b110;
    localparam logic [2:0] C_F3_SD = 3'b111;

    // funct3 codes of full-length loads; the first has no meaning
    localparam logic [2:0] F3_LOAD_BAD = 3'b111;
    localparam logic [2:0] F3_LOAD_LWU = 3'b110;
    localparam logic [2:0] F3_LOAD_SGN = 3'b010;

    // access widths
    localparam logic [1:0] WIDTH_BYTE   = 2'd0;
    localparam logic [1:0] WIDTH_WORD   = 2'd2;
    localparam logic [1:0] WIDTH_DOUBLE = 2'd3;

    // instruction lengths
    localparam logic [2:0] PC_ADV_COMP = 3'd2;
    localparam logic [2:0] PC_ADV_FULL = 3'd4;

    // upper bits of a compressed register number (x8..x15)
    localparam logic [1:0] C_REG_HI = 2'b01;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [31:0]         instruction;
        logic [REG_BITS-1:0] reg_index;
        logic [XLEN-1:0]     wr_value;
    } req_t;

    typedef struct packed {
        logic [XLEN-1:0]     address;
        logic [1:0]          access_width;
        logic [REG_BITS-1:0] data_regno;
        logic [2:0]          insn_len;
        logic                load_signed;
        logic                unsupported;
    } rsp_t;

    // decode result handed from the decoder to the address stage
    typedef struct packed {
        logic                ok;
        logic [REG_BITS-1:0] base_idx;
        logic [XLEN-1:0]     offset;
        logic [1:0]          width;
        logic [REG_BITS-1:0] dreg;
        logic [2:0]          adv;
        logic                sgn;
    } dec_t;

endpackage

@@ rtl/rlsad_req_if.sv @@
interface rlsad_req_if
    import rlsad_pkg::*;
();
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/rlsad_rsp_if.sv @@
interface rlsad_rsp_if
    import rlsad_pkg::*;
();
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/rlsad_regfile.sv @@
module rlsad_regfile
    import rlsad_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                we,
    input  logic [REG_BITS-1:0] waddr,
    input  logic [XLEN-1:0]     wdata,
    input  logic [REG_BITS-1:0] raddr,
    output logic [XLEN-1:0]     rdata
);

    // x1..x31, entry i holds x(i+1)
    logic [XLEN-1:0] regs_reg [NUM_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                regs_reg[i] <= '0;
            end
        end
        else if (we && (waddr != '0))
        begin
            regs_reg[waddr - REG_BITS'(1)] <= wdata;
        end
    end

    // x0 reads as zero
    assign rdata = (raddr == '0) ? '0 : regs_reg[raddr - REG_BITS'(1)];

endmodule

@@ rtl/rlsad_decode.sv @@
module rlsad_decode
    import rlsad_pkg::*;
(
    input  logic [1:0]  cmd,
    input  logic [31:0] instruction,
    output dec_t        dec
);

    logic [15:0] h;
    logic [2:0]  f3;
    logic [2:0]  cf3;
    logic        is_w;
    logic        is_d;

    assign h   = instruction[15:0];
    assign f3  = instruction[14:12];
    assign cf3 = h[15:13];

    assign is_w = (h[1:0] == C_QUAD0) &&
                  (((cmd == CMD_LOAD) && (cf3 == C_F3_LW)) ||
                   ((cmd == CMD_STORE) && (cf3 == C_F3_SW)));
    assign is_d = (h[1:0] == C_QUAD0) &&
                  (((cmd == CMD_LOAD) && (cf3 == C_F3_LD)) ||
                   ((cmd == CMD_STORE) && (cf3 == C_F3_SD)));

    always_comb
    begin
        dec          = '0;
        dec.base_idx = instruction[19:15];
        if (instruction[1:0] == LEN_FULL)
        begin
            dec.adv = PC_ADV_FULL;
            if ((cmd == CMD_LOAD) && (instruction[6:0] == OPC_LOAD) &&
                (f3 != F3_LOAD_BAD))
            begin
                dec.ok     = 1'b1;
                dec.offset = {{(XLEN-12){instruction[31]}}, instruction[31:20]};
                dec.dreg   = instruction[11:7];
                dec.width  = f3[1:0];
                dec.sgn    = (f3 <= F3_LOAD_SGN);
            end
            else if ((cmd == CMD_STORE) && (instruction[6:0] == OPC_STORE) &&
                     !f3[2])
            begin
                dec.ok     = 1'b1;
                dec.offset = {{(XLEN-12){instruction[31]}},
                              instruction[31:25], instruction[11:7]};
                dec.dreg   = instruction[24:20];
                dec.width  = f3[1:0];
            end
        end
        else
        begin
            dec.adv      = PC_ADV_COMP;
            dec.base_idx = {C_REG_HI, h[9:7]};
            if (is_w)
            begin
                dec.ok     = 1'b1;
                dec.offset = {{(XLEN-7){1'b0}}, h[5], h[12:10], h[6], 2'b00};
                dec.dreg   = {C_REG_HI, h[4:2]};
                dec.width  = WIDTH_WORD;
                dec.sgn    = (cmd == CMD_LOAD);
            end
            else if (is_d)
            begin
                dec.ok     = 1'b1;
                dec.offset = {{(XLEN-8){1'b0}}, h[6], h[5], h[12:10], 3'b000};
                dec.dreg   = {C_REG_HI, h[4:2]};
                dec.width  = WIDTH_DOUBLE;
            end
        end
    end

endmodule

@@ rtl/riscv_load_store_address_decoder.sv @@
// a decode transfer is registered in the input stage, then its result in the result register
// throughput: one transfer per cycle while the receiver takes results, set by the single input register and
// the single result register with the decode and 64-bit add between them
// register writes give no result and leave the pipeline in the cycle after acceptance
// reset: asynchronous, clears both stage valids and all 31 guest registers to zero
module riscv_load_store_address_decoder
    import rlsad_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    rlsad_req_if.sink    req,
    rlsad_rsp_if.source  rsp
);

`include "riscv_load_store_address_decoder_macros.svh"

    // input stage
    logic s1_valid_reg;
    logic s1_valid_next;
    req_t s1_data_reg;
    req_t s1_data_next;

    // result stage
    logic rsp_valid_reg;
    logic rsp_valid_next;
    rsp_t rsp_data_reg;
    rsp_t rsp_data_next;

    logic            s1_is_write;
    logic            rsp_free;
    logic            s1_move;
    logic            take_in;
    dec_t            dec;
    logic [XLEN-1:0] base_value;

    // a register write needs no result slot, so it leaves even while the
    // result stage is stalled; a decode leaves only when the slot is free
    assign s1_is_write = (s1_data_reg.cmd == CMD_WRITE);
    assign rsp_free    = !rsp_valid_reg || rsp.ready;
    assign s1_move     = s1_valid_reg && (s1_is_write || rsp_free);

    // the input register takes a new transfer when empty or emptying
    assign req.ready = !s1_valid_reg || s1_move;
    assign take_in   = req.valid && req.ready;

    // the write is applied as the item leaves the input stage, so a decode
    // behind it, once in the input stage, reads the updated file without forwarding
    rlsad_regfile u_regfile (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (s1_move && s1_is_write),
        .waddr (s1_data_reg.reg_index),
        .wdata (s1_data_reg.wr_value),
        .raddr (dec.base_idx),
        .rdata (base_value)
    );

    rlsad_decode u_decode (
        .cmd         (s1_data_reg.cmd),
        .instruction (s1_data_reg.instruction),
        .dec         (dec)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_data_next  = s1_data_reg;
        if (take_in)
        begin
            s1_valid_next = 1'b1;
            s1_data_next  = req.data;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // result formation: unhandled encodings keep only the length and the unsupported flag
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (s1_move && !s1_is_write)
        begin
            rsp_valid_next             = 1'b1;
            rsp_data_next.address      = dec.ok ? (base_value + dec.offset) : '0;
            rsp_data_next.access_width = dec.ok ? dec.width : WIDTH_BYTE;
            rsp_data_next.data_regno   = dec.ok ? dec.dreg : '0;
            rsp_data_next.insn_len     = dec.adv;
            rsp_data_next.load_signed  = dec.ok && dec.sgn;
            rsp_data_next.unsupported  = !dec.ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge clk)
    begin
        s1_data_reg  <= s1_data_next;
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    // an item held in the input stage is never overwritten
    `RLSAD_NEXT(a_s1_hold, s1_valid_reg && !s1_move, s1_valid_reg && $stable(s1_data_reg))
    // a new result only ever comes from a decode item in the input stage
    `RLSAD_IMPLIES(a_rsp_source, $rose(rsp_valid_reg), $past(s1_valid_reg && !s1_is_write))
    // an unsupported result carries no access information
    `RLSAD_IMPLIES(a_unsup_clear,
        rsp_valid_reg && rsp_data_reg.unsupported,
        (rsp_data_reg.address == '0) && (rsp_data_reg.access_width == WIDTH_BYTE) &&
        (rsp_data_reg.data_regno == '0) && !rsp_data_reg.load_signed)
    // a handled compressed access is always a word or doubleword
    `RLSAD_IMPLIES(a_comp_width,
        rsp_valid_reg && !rsp_data_reg.unsupported && (rsp_data_reg.insn_len == PC_ADV_COMP),
        (rsp_data_reg.access_width == WIDTH_WORD) ||
        (rsp_data_reg.access_width == WIDTH_DOUBLE))

endmodule

@@ sim/riscv_load_store_address_decoder_tb.sv @@
module riscv_load_store_address_decoder_tb
    import rlsad_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // codes that the package leaves unnamed
    localparam logic [1:0] CMD_NONE   = 2'd3;
    localparam logic [1:0] C_QUAD1    = 2'b01;
    localparam logic [2:0] F3_B       = 3'b000;
    localparam logic [2:0] F3_H       = 3'b001;
    localparam logic [2:0] F3_W       = 3'b010;
    localparam logic [2:0] F3_D       = 3'b011;
    localparam logic [2:0] F3_BU      = 3'b100;
    localparam logic [2:0] F3_HU      = 3'b101;

    localparam int RANDOM_ITEMS = 1800;
    localparam int STALL_LIMIT  = 2000;
    localparam int GAP_PERCENT  = 33;

    typedef struct {
        req_t item;
        bit   known;
        rsp_t want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    rlsad_req_if req_bus ();
    rlsad_rsp_if rsp_bus ();

    riscv_load_store_address_decoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // private copy of the guest register file, x1..x31
    logic [XLEN-1:0] guest_copy [1:NUM_REGS];
    rsp_t            expected_accesses [$];
    stim_row_t       directed_rows [$];

    bit steady;
    int n_errors = 0;
    int n_writes;
    int n_decodes;
    int n_compressed;
    int n_results = 0;
    int n_unsupported = 0;
    int stall_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // ---------------------------------------------------------------
    // instruction encoders
    // ---------------------------------------------------------------

    function automatic logic [31:0] enc_load(logic [2:0] f3, logic [4:0] rd, logic [4:0] rs1,
                                             logic [11:0] imm);
        return {imm, rs1, f3, rd, OPC_LOAD};
    endfunction

    function automatic logic [31:0] enc_store(logic [2:0] f3, logic [4:0] rs2, logic [4:0] rs1,
                                              logic [11:0] imm);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
    endfunction

    // compressed quadrant-zero load/store; bit 6 carries off[2] for words, off[7] for doubles
    function automatic logic [15:0] enc_cmem(logic [2:0] f3, logic [2:0] rdp, logic [2:0] rsp,
                                             logic [7:0] off);
        return {f3, off[5:3], rsp, (f3[0] ? off[7] : off[2]), off[6], rdp, C_QUAD0};
    endfunction

    function automatic req_t request(logic [1:0] cmd, logic [31:0] ins, logic [4:0] idx,
                                     logic [63:0] value);
        req_t it;
        it.cmd         = cmd;
        it.instruction = ins;
        it.reg_index   = idx;
        it.wr_value    = value;
        return it;
    endfunction

    function automatic rsp_t access_result(logic [63:0] addr, logic [1:0] width,
                                           logic [4:0] dreg, logic [2:0] adv,
                                           logic sgn, logic unsup);
        rsp_t r;
        r.address      = addr;
        r.access_width = width;
        r.data_regno   = dreg;
        r.insn_len     = adv;
        r.load_signed  = sgn;
        r.unsupported  = unsup;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    function automatic logic [XLEN-1:0] base_value(logic [4:0] idx);
        return (idx == 5'd0) ? '0 : guest_copy[idx];
    endfunction

    // works out address, width and register of one decode transfer
    function automatic rsp_t decode_access(req_t item);
        rsp_t        r;
        logic [31:0] ins;
        logic [15:0] half;
        logic [2:0]  f3;
        logic [11:0] imm;
        logic [7:0]  coff;
        logic        is_w;
        logic        is_d;
        r   = '0;
        ins = item.instruction;
        if (ins[1:0] == LEN_FULL)
        begin
            r.insn_len = PC_ADV_FULL;
            f3 = ins[14:12];
            if (item.cmd == CMD_LOAD && ins[6:0] == OPC_LOAD && f3 != F3_LOAD_BAD)
            begin
                imm            = ins[31:20];
                r.address      = base_value(ins[19:15]) + {{52{imm[11]}}, imm};
                r.data_regno   = ins[11:7];
                r.access_width = f3[1:0];
                r.load_signed  = (f3 <= F3_LOAD_SGN);
            end
            else if (item.cmd == CMD_STORE && ins[6:0] == OPC_STORE && f3[2] == 1'b0)
            begin
                imm            = {ins[31:25], ins[11:7]};
                r.address      = base_value(ins[19:15]) + {{52{imm[11]}}, imm};
                r.data_regno   = ins[24:20];
                r.access_width = f3[1:0];
            end
            else
            begin
                r.unsupported = 1'b1;
            end
        end
        else
        begin
            // compressed: only the low half counts
            r.insn_len = PC_ADV_COMP;
            half = ins[15:0];
            f3   = half[15:13];
            is_w = (half[1:0] == C_QUAD0) &&
                   ((item.cmd == CMD_LOAD && f3 == C_F3_LW) ||
                    (item.cmd == CMD_STORE && f3 == C_F3_SW));
            is_d = (half[1:0] == C_QUAD0) &&
                   ((item.cmd == CMD_LOAD && f3 == C_F3_LD) ||
                    (item.cmd == CMD_STORE && f3 == C_F3_SD));
            if (is_w || is_d)
            begin
                coff = is_w ? {1'b0, half[5], half[12:10], half[6], 2'b00}
                            : {half[6], half[5], half[12:10], 3'b000};
                r.address      = base_value({C_REG_HI, half[9:7]}) + {56'd0, coff};
                r.data_regno   = {C_REG_HI, half[4:2]};
                r.access_width = is_w ? WIDTH_WORD : WIDTH_DOUBLE;
                r.load_signed  = is_w && item.cmd == CMD_LOAD;
            end
            else
            begin
                r.unsupported = 1'b1;
            end
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // random stimulus
    // ---------------------------------------------------------------

    function automatic logic [63:0] pick_value();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            3: return 64'h7FFF_FFFF_FFFF_FFFF;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [11:0] pick_imm();
        case ($urandom_range(7))
            0: return 12'h7FF;
            1: return 12'h800;
            2: return 12'hFFF;
            3: return 12'h000;
            default: return 12'($urandom);
        endcase
    endfunction

    // mostly well-formed accesses with random content, then writes and noise
    function automatic req_t random_item();
        req_t        it;
        int unsigned pick;
        logic [2:0]  f3;
        it.cmd         = CMD_WRITE;
        it.instruction = $urandom;
        // favour x8..x15 so that the compressed forms see live bases
        it.reg_index   = ($urandom_range(1) == 1) ? {C_REG_HI, 3'($urandom_range(7))}
                                                  : 5'($urandom_range(31));
        it.wr_value    = pick_value();
        pick = $urandom_range(99);
        if (pick >= 25 && pick < 50)
        begin
            it.cmd         = CMD_LOAD;
            it.instruction = enc_load(3'($urandom_range(6)), 5'($urandom), 5'($urandom),
                                      pick_imm());
        end
        else if (pick >= 50 && pick < 65)
        begin
            it.cmd         = CMD_STORE;
            it.instruction = enc_store(3'($urandom_range(3)), 5'($urandom), 5'($urandom),
                                       pick_imm());
        end
        else if (pick >= 65 && pick < 85)
        begin
            case ($urandom_range(3))
                0: f3 = C_F3_LW;
                1: f3 = C_F3_LD;
                2: f3 = C_F3_SW;
                default: f3 = C_F3_SD;
            endcase
            it.cmd         = f3[2] ? CMD_STORE : CMD_LOAD;
            it.instruction = {16'($urandom),
                              enc_cmem(f3, 3'($urandom), 3'($urandom), 8'($urandom))};
        end
        else if (pick >= 85)
        begin
            // noise: any command, any word, sometimes with a memory opcode
            it.cmd = 2'($urandom_range(3));
            if ($urandom_range(1) == 1)
            begin
                it.instruction[6:0] = ($urandom_range(1) == 1) ? OPC_LOAD : OPC_STORE;
            end
        end
        return it;
    endfunction

    // ---------------------------------------------------------------
    // request side
    // ---------------------------------------------------------------

    // drives one transfer from the falling edge, waits for acceptance and books the result
    task automatic send(req_t item, bit known, rsp_t want);
        @(negedge clk);
        while (!steady && $urandom_range(99) < GAP_PERCENT)
        begin
            req_bus.valid <= 1'b0;
            req_bus.data  <= request(2'($urandom), $urandom, 5'($urandom), {$urandom, $urandom});
            @(negedge clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.data  <= item;
        do
        begin
            @(posedge clk);
        end
        while (!req_bus.ready);

        if (item.cmd == CMD_WRITE)
        begin
            n_writes++;
            if (item.reg_index != 5'd0)
            begin
                guest_copy[item.reg_index] = item.wr_value;
            end
        end
        else
        begin
            n_decodes++;
            if (item.instruction[1:0] != LEN_FULL)
            begin
                n_compressed++;
            end
            expected_accesses.push_back(known ? want : decode_access(item));
        end
    endtask

    task automatic add_plain(req_t item);
        stim_row_t row;
        row.item  = item;
        row.known = 1'b0;
        row.want  = '0;
        directed_rows.push_back(row);
    endtask

    task automatic add_known(req_t item, rsp_t want);
        stim_row_t row;
        row.item  = item;
        row.known = 1'b1;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    // ---------------------------------------------------------------
    // result side
    // ---------------------------------------------------------------

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (n_errors < 40)
        begin
            $display("mismatch at %0t after %0d results: %s got %h want %h",
                     $realtime, n_results, what, got, want);
        end
        n_errors++;
    endtask

    task automatic compare_field(string what, logic [63:0] got, logic [63:0] want);
        if (got !== want)
        begin
            report_mismatch(what, got, want);
        end
    endtask

    // receiver stalls at random, apart from the steady stretch
    always @(negedge clk)
    begin
        rsp_bus.ready <= steady || ($urandom_range(99) >= GAP_PERCENT);
    end

    // compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (expected_accesses.size() == 0)
            begin
                report_mismatch("unexpected result, address", rsp_bus.data.address, '0);
            end
            else
            begin
                want = expected_accesses.pop_front();
                compare_field("address", rsp_bus.data.address, want.address);
                compare_field("access_width", 64'(rsp_bus.data.access_width),
                              64'(want.access_width));
                compare_field("data_regno", 64'(rsp_bus.data.data_regno),
                              64'(want.data_regno));
                compare_field("insn_len", 64'(rsp_bus.data.insn_len), 64'(want.insn_len));
                compare_field("load_signed", 64'(rsp_bus.data.load_signed),
                              64'(want.load_signed));
                compare_field("unsupported", 64'(rsp_bus.data.unsupported),
                              64'(want.unsupported));
                if (want.unsupported)
                begin
                    n_unsupported++;
                end
            end
            n_results++;
        end
    end

    // watchdog: any transfer on either side clears the count
    always @(posedge clk)
    begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, expected_accesses.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial
    begin
        rst_n         = 1'b0;
        steady        = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.data  = '0;
        n_writes      = 0;
        n_decodes     = 0;
        n_compressed  = 0;
        for (int i = 1; i <= NUM_REGS; i++)
        begin
            guest_copy[i] = '0;
        end

        // directed rows: typed results where they follow at a glance
        // register file is clear after reset
        add_known(request(CMD_LOAD, enc_load(F3_D, 5'd5, 5'd1, 12'h010), 5'd0, '0),
                  access_result(64'h10, WIDTH_DOUBLE, 5'd5, PC_ADV_FULL, 1'b0, 1'b0));
        // write to x0 is dropped, x0 still reads zero
        add_plain(request(CMD_WRITE, '0, 5'd0, '1));
        add_known(request(CMD_LOAD, enc_load(F3_B, 5'd31, 5'd0, 12'hFFF), 5'd0, '0),
                  access_result('1, WIDTH_BYTE, 5'd31, PC_ADV_FULL, 1'b1, 1'b0));
        // address wraps past the top
        add_plain(request(CMD_WRITE, '0, 5'd1, '1));
        add_known(request(CMD_LOAD, enc_load(F3_W, 5'd2, 5'd1, 12'h7FF), 5'd0, '0),
                  access_result(64'h7FE, WIDTH_WORD, 5'd2, PC_ADV_FULL, 1'b1, 1'b0));
        add_plain(request(CMD_WRITE, '0, 5'd31, 64'h8000_0000_0000_0000));
        add_known(request(CMD_STORE, enc_store(F3_D, 5'd31, 5'd31, 12'h800), 5'd0, '0),
                  access_result(64'h7FFF_FFFF_FFFF_F800, WIDTH_DOUBLE, 5'd31, PC_ADV_FULL,
                                1'b0, 1'b0));
        // remaining load and store widths
        add_plain(request(CMD_LOAD, enc_load(F3_H, 5'd3, 5'd31, 12'hFFE), 5'd0, '0));
        add_plain(request(CMD_LOAD, enc_load(F3_BU, 5'd4, 5'd1, 12'h001), 5'd0, '0));
        add_plain(request(CMD_LOAD, enc_load(F3_HU, 5'd6, 5'd31, 12'h123), 5'd0, '0));
        add_plain(request(CMD_LOAD, enc_load(F3_LOAD_LWU, 5'd7, 5'd1, 12'h456), 5'd0, '0));
        add_plain(request(CMD_STORE, enc_store(F3_B, 5'd1, 5'd1, 12'h000), 5'd0, '0));
        add_plain(request(CMD_STORE, enc_store(F3_H, 5'd9, 5'd31, 12'h7FF), 5'd0, '0));
        add_plain(request(CMD_STORE, enc_store(F3_W, 5'd0, 5'd0, 12'hABC), 5'd0, '0));
        // encodings that must be flagged, full length
        add_known(request(CMD_LOAD, enc_load(F3_LOAD_BAD, 5'd3, 5'd1, 12'h010), 5'd0, '0),
                  access_result('0, WIDTH_BYTE, 5'd0, PC_ADV_FULL, 1'b0, 1'b1));
        add_known(request(CMD_STORE, enc_store(F3_BU, 5'd3, 5'd1, 12'h010), 5'd0, '0),
                  access_result('0, WIDTH_BYTE, 5'd0, PC_ADV_FULL, 1'b0, 1'b1));
        add_known(request(CMD_LOAD, enc_store(F3_W, 5'd3, 5'd1, 12'h010), 5'd0, '0),
                  access_result('0, WIDTH_BYTE, 5'd0, PC_ADV_FULL, 1'b0, 1'b1));
        add_known(request(CMD_NONE, enc_load(F3_D, 5'd3, 5'd1, 12'h010), 5'd0, '0),
                  access_result('0, WIDTH_BYTE, 5'd0, PC_ADV_FULL, 1'b0, 1'b1));
        // compressed forms, mostly at their largest offsets, high half ignored
        add_plain(request(CMD_WRITE, '0, 5'd8, 64'hFFFF_FFFF_FFFF_FF00));
        add_plain(request(CMD_WRITE, '0, 5'd15, 64'h1234_5678_9ABC_DEF0));
        add_plain(request(CMD_LOAD, {16'h0, enc_cmem(C_F3_LW, 3'd7, 3'd0, 8'd124)}, 5'd0, '0));
        add_plain(request(CMD_LOAD, {16'h0, enc_cmem(C_F3_LD, 3'd0, 3'd7, 8'd248)}, 5'd0, '0));
        add_plain(request(CMD_STORE, {16'h0, enc_cmem(C_F3_SW, 3'd3, 3'd7, 8'd0)}, 5'd0, '0));
        add_plain(request(CMD_STORE, {16'hFFFF, enc_cmem(C_F3_SD, 3'd5, 3'd0, 8'd248)},
                          5'd0, '0));
        // compressed encodings that must be flagged
        add_known(request(CMD_LOAD, {16'h0, 14'h1000, C_QUAD1}, 5'd0, '0),
                  access_result('0, WIDTH_BYTE, 5'd0, PC_ADV_COMP, 1'b0, 1'b1));
        add_known(request(CMD_STORE, {16'h0, enc_cmem(C_F3_LW, 3'd1, 3'd2, 8'd4)}, 5'd0, '0),
                  access_result('0, WIDTH_BYTE, 5'd0, PC_ADV_COMP, 1'b0, 1'b1));
        add_known(request(CMD_NONE, {16'h0, enc_cmem(C_F3_LD, 3'd1, 3'd2, 8'd8)}, 5'd0, '0),
                  access_result('0, WIDTH_BYTE, 5'd0, PC_ADV_COMP, 1'b0, 1'b1));

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            send(directed_rows[i].item, directed_rows[i].known, directed_rows[i].want);
        end

        // random part, with a stretch where neither side pauses
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            steady = (i >= 600 && i < 900);
            send(random_item(), 1'b0, '0);
        end
        steady = 1'b0;

        @(negedge clk);
        req_bus.valid <= 1'b0;

        // drain, then keep watching to catch any stray result
        while (expected_accesses.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        $display("covered %0d register writes and %0d decodes, %0d of them compressed",
                 n_writes, n_decodes, n_compressed);
        $display("checked %0d results, %0d flagged unsupported, %0d mismatches",
                 n_results, n_unsupported, n_errors);
        if (n_errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
